// ===== src/mpco_pkg.sv =====
`default_nettype none

package mpco_pkg;

  // Operation codes held in the op_mode register
  typedef enum logic [1:0] {
    OP_FILL    = 2'd0,
    OP_PAINT   = 2'd1,
    OP_DESAT   = 2'd2,
    OP_EXTRACT = 2'd3
  } op_t;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_OP_MODE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_RED   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_GREEN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_BLUE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_ALPHA = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DESAT_PCT   = 3'd5;

  localparam logic [7:0] FULL_SCALE    = 8'd255;
  localparam logic [6:0] PERCENT_SCALE = 7'd100;

  // Red in the lowest byte
  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pix_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] col_red;
    logic [7:0] col_green;
    logic [7:0] col_blue;
    logic [7:0] col_alpha;
    logic [6:0] pct;       // already limited to 100
  } cfg_t;

  // After the first products
  typedef struct packed {
    pix_t        pix;
    logic        mask;
    logic        last;
    logic [15:0] dx;       // da * (255 - a)
    logic [15:0] ca_r;
    logic [15:0] ca_g;
    logic [15:0] ca_b;
    logic [9:0]  sum;      // r + g + b
    logic [6:0]  pinv;     // 100 - p
  } s1_t;

  // Numerators ready for division
  typedef struct packed {
    pix_t        pix;
    logic        mask;
    logic        last;
    logic [23:0] num_r;
    logic [23:0] num_g;
    logic [23:0] num_b;
    logic [15:0] na;
    logic [16:0] sp;       // (r + g + b) * p
    logic [14:0] t_r;
    logic [14:0] t_g;
    logic [14:0] t_b;
  } s2_t;

  // Numerators with estimated quotients
  typedef struct packed {
    pix_t        pix;
    logic        mask;
    logic        last;
    logic [23:0] num_r;
    logic [23:0] num_g;
    logic [23:0] num_b;
    logic [7:0]  qn_r;
    logic [7:0]  qn_g;
    logic [7:0]  qn_b;
    logic [15:0] na;
    logic [7:0]  qa;
    logic [16:0] sp;
    logic [7:0]  qs;
    logic [14:0] t_r;
    logic [14:0] t_g;
    logic [14:0] t_b;
    logic [7:0]  qt_r;
    logic [7:0]  qt_g;
    logic [7:0]  qt_b;
  } s3_t;

  // Exact quotients
  typedef struct packed {
    pix_t       pix;
    logic       mask;
    logic       last;
    logic [7:0] pq_r;
    logic [7:0] pq_g;
    logic [7:0] pq_b;
    logic [7:0] aq;
    logic [7:0] avg;
    logic [7:0] dq_r;
    logic [7:0] dq_g;
    logic [7:0] dq_b;
  } s4_t;

endpackage

`default_nettype wire

// ===== src/mpco_cfg_regs.sv =====
`default_nettype none

module mpco_cfg_regs
  import mpco_pkg::*;
(
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  cfg_valid,
  output logic                 cfg_ready,
  input  wire [CFG_IDX_W-1:0]  cfg_index,
  input  wire [7:0]            cfg_data,
  output cfg_t                 cfg
);

  op_t        op_r;
  logic [7:0] red_r;
  logic [7:0] green_r;
  logic [7:0] blue_r;
  logic [7:0] alpha_r;
  logic [6:0] pct_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r    <= OP_FILL;
      red_r   <= 8'd0;
      green_r <= 8'd0;
      blue_r  <= 8'd0;
      alpha_r <= 8'd0;
      pct_r   <= 7'd0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_OP_MODE:     op_r    <= op_t'(cfg_data[1:0]);
        REG_COLOR_RED:   red_r   <= cfg_data;
        REG_COLOR_GREEN: green_r <= cfg_data;
        REG_COLOR_BLUE:  blue_r  <= cfg_data;
        REG_COLOR_ALPHA: alpha_r <= cfg_data;
        REG_DESAT_PCT:   pct_r   <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // Saturate percent above one hundred
  always_comb begin
    cfg.op        = op_r;
    cfg.col_red   = red_r;
    cfg.col_green = green_r;
    cfg.col_blue  = blue_r;
    cfg.col_alpha = alpha_r;
    cfg.pct       = (pct_r > PERCENT_SCALE) ? PERCENT_SCALE : pct_r;
  end

  a_pct_limit: assert property (@(posedge clk) disable iff (!rst_n)
    cfg.pct <= PERCENT_SCALE)
    else $error("clamped percent above one hundred");

endmodule

`default_nettype wire

// ===== src/mpco_front.sv =====
`default_nettype none

module mpco_front
  import mpco_pkg::*;
(
  input  wire   clk,
  input  wire   rst_n,
  input  cfg_t  cfg,
  input  wire   in_valid,
  output logic  in_ready,
  input  pix_t  in_pix,
  input  wire   in_mask,
  input  wire   in_last,
  output logic  out_valid,
  input  wire   out_ready,
  output s2_t   out_data
);

  logic v1_r;
  logic v2_r;
  s1_t  s1_r;
  s2_t  s2_r;
  s1_t  s1_nxt;
  s2_t  s2_nxt;
  logic load1;
  logic load2;

  assign load2     = !v2_r || out_ready;
  assign load1     = !v1_r || load2;
  assign in_ready  = load1;
  assign out_valid = v2_r;
  assign out_data  = s2_r;

  // Stage 1: first products and channel sum
  always_comb begin
    s1_nxt.pix  = in_pix;
    s1_nxt.mask = in_mask;
    s1_nxt.last = in_last;
    s1_nxt.dx   = 16'(in_pix.alpha) * 16'(FULL_SCALE - cfg.col_alpha);
    s1_nxt.ca_r = 16'(cfg.col_red)   * 16'(cfg.col_alpha);
    s1_nxt.ca_g = 16'(cfg.col_green) * 16'(cfg.col_alpha);
    s1_nxt.ca_b = 16'(cfg.col_blue)  * 16'(cfg.col_alpha);
    s1_nxt.sum  = 10'(in_pix.red) + 10'(in_pix.green) + 10'(in_pix.blue);
    s1_nxt.pinv = PERCENT_SCALE - cfg.pct;
  end

  // Stage 2: full numerators; x*255 taken as (x << 8) - x
  always_comb begin
    s2_nxt.pix   = s1_r.pix;
    s2_nxt.mask  = s1_r.mask;
    s2_nxt.last  = s1_r.last;
    s2_nxt.num_r = 24'(24'(s1_r.pix.red) * 24'(s1_r.dx)
                   + ({8'd0, s1_r.ca_r} << 8) - {8'd0, s1_r.ca_r});
    s2_nxt.num_g = 24'(24'(s1_r.pix.green) * 24'(s1_r.dx)
                   + ({8'd0, s1_r.ca_g} << 8) - {8'd0, s1_r.ca_g});
    s2_nxt.num_b = 24'(24'(s1_r.pix.blue) * 24'(s1_r.dx)
                   + ({8'd0, s1_r.ca_b} << 8) - {8'd0, s1_r.ca_b});
    s2_nxt.na    = 16'({1'b0, s1_r.dx} + ({9'd0, cfg.col_alpha} << 8)
                   - {9'd0, cfg.col_alpha});
    s2_nxt.sp    = 17'(s1_r.sum) * 17'(cfg.pct);
    s2_nxt.t_r   = 15'(s1_r.pix.red)   * 15'(s1_r.pinv);
    s2_nxt.t_g   = 15'(s1_r.pix.green) * 15'(s1_r.pinv);
    s2_nxt.t_b   = 15'(s1_r.pix.blue)  * 15'(s1_r.pinv);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (load1) v1_r <= in_valid;
      if (load2) v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (load1 && in_valid) s1_r <= s1_nxt;
    if (load2 && v1_r)     s2_r <= s2_nxt;
  end

endmodule

`default_nettype wire

// ===== src/mpco_div.sv =====
`default_nettype none

module mpco_div
  import mpco_pkg::*;
(
  input  wire   clk,
  input  wire   rst_n,
  input  wire   in_valid,
  output logic  in_ready,
  input  s2_t   in_data,
  output logic  out_valid,
  input  wire   out_ready,
  output s4_t   out_data
);

  // Reciprocals rounded down, so each estimate is exact or one short
  localparam logic [23:0] DEN_PAINT  = 24'd65025;
  localparam logic [15:0] DEN_ALPHA  = 16'd255;
  localparam logic [16:0] DEN_AVG    = 17'd300;
  localparam logic [14:0] DEN_PCT    = 15'd100;
  localparam logic [8:0]  RCP_PAINT  = 9'd258;     // 2^24 / 65025
  localparam logic [8:0]  RCP_ALPHA  = 9'd257;     // 2^16 / 255
  localparam logic [15:0] RCP_AVG    = 16'd55924;  // 2^24 / 300
  localparam logic [9:0]  RCP_PCT    = 10'd655;    // 2^16 / 100

  function automatic logic [7:0] est_paint(input logic [23:0] n);
    logic [32:0] p;
    p = 33'(n) * 33'(RCP_PAINT);
    return p[31:24];
  endfunction

  function automatic logic [7:0] est_alpha(input logic [15:0] n);
    logic [24:0] p;
    p = 25'(n) * 25'(RCP_ALPHA);
    return p[23:16];
  endfunction

  function automatic logic [7:0] est_avg(input logic [16:0] n);
    logic [32:0] p;
    p = 33'(n) * 33'(RCP_AVG);
    return p[31:24];
  endfunction

  function automatic logic [7:0] est_pct(input logic [14:0] n);
    logic [24:0] p;
    p = 25'(n) * 25'(RCP_PCT);
    return p[23:16];
  endfunction

  logic v3_r;
  logic v4_r;
  s3_t  s3_r;
  s4_t  s4_r;
  s3_t  s3_nxt;
  s4_t  s4_nxt;
  logic load3;
  logic load4;

  logic [23:0] rem_r;
  logic [23:0] rem_g;
  logic [23:0] rem_b;
  logic [15:0] rem_a;
  logic [16:0] rem_s;
  logic [14:0] rem_tr;
  logic [14:0] rem_tg;
  logic [14:0] rem_tb;

  assign load4     = !v4_r || out_ready;
  assign load3     = !v3_r || load4;
  assign in_ready  = load3;
  assign out_valid = v4_r;
  assign out_data  = s4_r;

  // Stage 3: reciprocal estimates
  always_comb begin
    s3_nxt.pix   = in_data.pix;
    s3_nxt.mask  = in_data.mask;
    s3_nxt.last  = in_data.last;
    s3_nxt.num_r = in_data.num_r;
    s3_nxt.num_g = in_data.num_g;
    s3_nxt.num_b = in_data.num_b;
    s3_nxt.qn_r  = est_paint(in_data.num_r);
    s3_nxt.qn_g  = est_paint(in_data.num_g);
    s3_nxt.qn_b  = est_paint(in_data.num_b);
    s3_nxt.na    = in_data.na;
    s3_nxt.qa    = est_alpha(in_data.na);
    s3_nxt.sp    = in_data.sp;
    s3_nxt.qs    = est_avg(in_data.sp);
    s3_nxt.t_r   = in_data.t_r;
    s3_nxt.t_g   = in_data.t_g;
    s3_nxt.t_b   = in_data.t_b;
    s3_nxt.qt_r  = est_pct(in_data.t_r);
    s3_nxt.qt_g  = est_pct(in_data.t_g);
    s3_nxt.qt_b  = est_pct(in_data.t_b);
  end

  // Stage 4: remainder check, bump the estimate by one where short
  always_comb begin
    rem_r  = s3_r.num_r - 24'(s3_r.qn_r) * DEN_PAINT;
    rem_g  = s3_r.num_g - 24'(s3_r.qn_g) * DEN_PAINT;
    rem_b  = s3_r.num_b - 24'(s3_r.qn_b) * DEN_PAINT;
    rem_a  = s3_r.na    - 16'(s3_r.qa)   * DEN_ALPHA;
    rem_s  = s3_r.sp    - 17'(s3_r.qs)   * DEN_AVG;
    rem_tr = s3_r.t_r   - 15'(s3_r.qt_r) * DEN_PCT;
    rem_tg = s3_r.t_g   - 15'(s3_r.qt_g) * DEN_PCT;
    rem_tb = s3_r.t_b   - 15'(s3_r.qt_b) * DEN_PCT;

    s4_nxt.pix  = s3_r.pix;
    s4_nxt.mask = s3_r.mask;
    s4_nxt.last = s3_r.last;
    s4_nxt.pq_r = s3_r.qn_r + 8'(rem_r  >= DEN_PAINT);
    s4_nxt.pq_g = s3_r.qn_g + 8'(rem_g  >= DEN_PAINT);
    s4_nxt.pq_b = s3_r.qn_b + 8'(rem_b  >= DEN_PAINT);
    s4_nxt.aq   = s3_r.qa   + 8'(rem_a  >= DEN_ALPHA);
    s4_nxt.avg  = s3_r.qs   + 8'(rem_s  >= DEN_AVG);
    s4_nxt.dq_r = s3_r.qt_r + 8'(rem_tr >= DEN_PCT);
    s4_nxt.dq_g = s3_r.qt_g + 8'(rem_tg >= DEN_PCT);
    s4_nxt.dq_b = s3_r.qt_b + 8'(rem_tb >= DEN_PCT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (load3) v3_r <= in_valid;
      if (load4) v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (load3 && in_valid) s3_r <= s3_nxt;
    if (load4 && v3_r)     s4_r <= s4_nxt;
  end

  a_paint_est: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r |-> (rem_r < 24'(2 * 65025) && rem_g < 24'(2 * 65025)
              && rem_b < 24'(2 * 65025)))
    else $error("paint quotient estimate off by more than one");

  a_desat_est: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r |-> (rem_s < 17'(2 * 300) && rem_tr < 15'(2 * 100)
              && rem_tg < 15'(2 * 100) && rem_tb < 15'(2 * 100)
              && rem_a < 16'(2 * 255)))
    else $error("desaturate or alpha estimate off by more than one");

endmodule

`default_nettype wire

// ===== src/mpco_select.sv =====
`default_nettype none

module mpco_select
  import mpco_pkg::*;
(
  input  wire   clk,
  input  wire   rst_n,
  input  cfg_t  cfg,
  input  wire   in_valid,
  output logic  in_ready,
  input  s4_t   in_data,
  output logic  out_valid,
  input  wire   out_ready,
  output pix_t  out_pix,
  output logic  out_last
);

  logic v5_r;
  pix_t pix_r;
  logic last_r;
  pix_t pix_nxt;
  logic load5;

  assign load5     = !v5_r || out_ready;
  assign in_ready  = load5;
  assign out_valid = v5_r;
  assign out_pix   = pix_r;
  assign out_last  = last_r;

  function automatic logic [7:0] sat8(input logic [7:0] x, input logic [7:0] y);
    logic [8:0] s;
    s = {1'b0, x} + {1'b0, y};
    return s[8] ? FULL_SCALE : s[7:0];
  endfunction

  always_comb begin
    pix_nxt = in_data.pix;
    case (cfg.op)
      OP_FILL: begin
        if (in_data.mask) begin
          pix_nxt.red   = cfg.col_red;
          pix_nxt.green = cfg.col_green;
          pix_nxt.blue  = cfg.col_blue;
          pix_nxt.alpha = cfg.col_alpha;
        end
      end
      OP_PAINT: begin
        if (in_data.mask) begin
          pix_nxt.red   = in_data.pq_r;
          pix_nxt.green = in_data.pq_g;
          pix_nxt.blue  = in_data.pq_b;
          pix_nxt.alpha = in_data.aq;
        end
      end
      OP_DESAT: begin
        if (in_data.mask) begin
          pix_nxt.red   = sat8(in_data.dq_r, in_data.avg);
          pix_nxt.green = sat8(in_data.dq_g, in_data.avg);
          pix_nxt.blue  = sat8(in_data.dq_b, in_data.avg);
        end
      end
      default: begin
        if (!in_data.mask) pix_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (load5) begin
      v5_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load5 && in_valid) begin
      pix_r  <= pix_nxt;
      last_r <= in_data.last;
    end
  end

endmodule

`default_nettype wire

// ===== src/masked_pixel_color_ops_top.sv =====
// Masked colour operations on an RGBA8 pixel stream.
// Input stream: in_tdata carries one pixel (red in the low byte, then green,
// blue, alpha), in_tuser the mask bit and in_tlast the end-of-image marker.
// Every input transaction gives exactly one output transaction on out_*, with
// out_tlast copying in_tlast. The operation (fill, paint alpha-over,
// desaturate, extract) and its colour and percent are set through the
// cfg_* write channel between passes; cfg_ready is always high.
// An input transaction passes five registered stages to out_tvalid: products,
// numerators, reciprocal estimates, remainder correction, output select.
// Throughput is one pixel per clock without stalls; every stage carries a valid
// bit and loads when it is empty or its successor loads, so bubbles close up.
// When the receiver stalls, the output register holds its transaction and
// the stages behind it keep filling; in_tready drops only once all five are
// full. The slowest path is a 24 by 9 bit reciprocal product in one stage.
// Reset clears all valid bits and every configuration register to zero, so
// the block comes up in fill mode with a black transparent colour.
`default_nettype none

module masked_pixel_color_ops_top
  import mpco_pkg::*;
(
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_tvalid,
  output logic                 in_tready,
  input  wire [31:0]           in_tdata,   // pix_red, pix_green, pix_blue, pix_alpha
  input  wire                  in_tuser,   // in_mask
  input  wire                  in_tlast,
  output logic                 out_tvalid,
  input  wire                  out_tready,
  output logic [31:0]          out_tdata,  // out_red, out_green, out_blue, out_alpha
  output logic                 out_tlast,
  input  wire                  cfg_valid,
  output logic                 cfg_ready,
  input  wire [CFG_IDX_W-1:0]  cfg_index,
  input  wire [7:0]            cfg_data
);

  cfg_t cfg;
  pix_t in_pix;
  pix_t out_pix;
  logic f_valid;
  logic f_ready;
  s2_t  f_data;
  logic d_valid;
  logic d_ready;
  s4_t  d_data;

  assign in_pix    = pix_t'(in_tdata);
  assign out_tdata = 32'(out_pix);

  mpco_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Stages 1 and 2: products and numerators
  mpco_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_pix    (in_pix),
    .in_mask   (in_tuser),
    .in_last   (in_tlast),
    .out_valid (f_valid),
    .out_ready (f_ready),
    .out_data  (f_data)
  );

  // Stages 3 and 4: constant division by reciprocal and correction
  mpco_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_data   (f_data),
    .out_valid (d_valid),
    .out_ready (d_ready),
    .out_data  (d_data)
  );

  // Stage 5: pick the result for the mode and mask, hold it for the receiver
  mpco_select u_select (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (d_valid),
    .in_ready  (d_ready),
    .in_data   (d_data),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_pix   (out_pix),
    .out_last  (out_tlast)
  );

  // Input back-pressure only arises from a stalled, full output
  a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && !out_tready))
    else $error("input stalled without an output stall");

endmodule

`default_nettype wire

// ===== verif/tb_masked_pixel_color_ops_top.sv =====
`timescale 1ns / 100ps

module tb_masked_pixel_color_ops_top
  import mpco_pkg::*;
();

  localparam int unsigned CH_MAX       = 255;
  localparam int unsigned PCT_FULL     = 100;
  localparam int unsigned RGB_CHANNELS = 3;
  localparam int unsigned HOLD_CYCLES  = 80;   // long receiver hold-off
  localparam int unsigned REPORT_LIMIT = 10;
  localparam int unsigned PHASES       = 14;
  localparam int unsigned PHASE_PIXELS = 75;

  // Indexes past the register list; writes to them must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

  typedef struct packed {
    pix_t pix;
    logic last;
  } result_t;

  // Receiver behaviour for one stretch of cycles
  typedef enum int unsigned {
    RX_ALWAYS,
    RX_HALF,
    RX_SPARSE,
    RX_MOSTLY
  } rx_style_e;

  // Shadow copy of the colour registers plus the queue of pixels still owed
  class colour_op_checker;
    op_t         op_mode;
    logic [7:0]  col_red;
    logic [7:0]  col_green;
    logic [7:0]  col_blue;
    logic [7:0]  col_alpha;
    logic [6:0]  desat_pct;
    result_t     expected_pixels[$];
    int unsigned mismatches;

    function new();
      op_mode    = OP_FILL;
      col_red    = '0;
      col_green  = '0;
      col_blue   = '0;
      col_alpha  = '0;
      desat_pct  = '0;
      mismatches = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [7:0] data);
      case (idx)
        REG_OP_MODE:     op_mode   = op_t'(data[1:0]);
        REG_COLOR_RED:   col_red   = data;
        REG_COLOR_GREEN: col_green = data;
        REG_COLOR_BLUE:  col_blue  = data;
        REG_COLOR_ALPHA: col_alpha = data;
        REG_DESAT_PCT:   desat_pct = data[6:0];
        default: ;
      endcase
    endfunction

    function logic [7:0] clamp8(int unsigned v);
      return (v > CH_MAX) ? 8'hFF : 8'(v);
    endfunction

    // Alpha-over of the register colour onto one channel
    function logic [7:0] over_channel(logic [7:0] c, logic [7:0] da, logic [7:0] col,
                                      logic [7:0] a);
      int unsigned num;
      num = int'(c) * int'(da) * (CH_MAX - int'(a)) + int'(col) * int'(a) * CH_MAX;
      return clamp8(num / (CH_MAX * CH_MAX));
    endfunction

    function result_t predict_pixel(pix_t p, logic mask, logic last);
      result_t     r;
      int unsigned pc;
      int unsigned avg;
      int unsigned a;
      r.pix  = p;
      r.last = last;
      case (op_mode)
        OP_FILL: begin
          if (mask) begin
            r.pix.red   = col_red;
            r.pix.green = col_green;
            r.pix.blue  = col_blue;
            r.pix.alpha = col_alpha;
          end
        end
        OP_PAINT: begin
          if (mask) begin
            a = col_alpha;
            r.pix.red   = over_channel(p.red, p.alpha, col_red, col_alpha);
            r.pix.green = over_channel(p.green, p.alpha, col_green, col_alpha);
            r.pix.blue  = over_channel(p.blue, p.alpha, col_blue, col_alpha);
            r.pix.alpha = clamp8((int'(p.alpha) * (CH_MAX - a) + CH_MAX * a) / CH_MAX);
          end
        end
        OP_DESAT: begin
          if (mask) begin
            pc  = (desat_pct > PCT_FULL) ? PCT_FULL : int'(desat_pct);
            avg = (int'(p.red) + int'(p.green) + int'(p.blue)) * pc
                  / (RGB_CHANNELS * PCT_FULL);
            r.pix.red   = clamp8(int'(p.red) * (PCT_FULL - pc) / PCT_FULL + avg);
            r.pix.green = clamp8(int'(p.green) * (PCT_FULL - pc) / PCT_FULL + avg);
            r.pix.blue  = clamp8(int'(p.blue) * (PCT_FULL - pc) / PCT_FULL + avg);
          end
        end
        default: begin
          if (!mask) r.pix = '0;
        end
      endcase
      return r;
    endfunction

    function void note_pixel(pix_t p, logic mask, logic last);
      expected_pixels.push_back(predict_pixel(p, mask, last));
    endfunction

    function void check_pixel(logic [31:0] data, logic last);
      result_t want;
      pix_t    got;
      got = pix_t'(data);
      if (expected_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("%0t: unexpected pixel rgba=%h last=%b", $time, data, last);
        return;
      end
      want = expected_pixels.pop_front();
      if (got.red !== want.pix.red || got.green !== want.pix.green ||
          got.blue !== want.pix.blue || got.alpha !== want.pix.alpha ||
          last !== want.last) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("%0t: pixel mismatch exp r=%0d g=%0d b=%0d a=%0d last=%b,",
                   $time, want.pix.red, want.pix.green, want.pix.blue, want.pix.alpha,
                   want.last,
                   " got r=%0d g=%0d b=%0d a=%0d last=%b",
                   got.red, got.green, got.blue, got.alpha, last);
      end
    endfunction

    function int unsigned pending();
      return expected_pixels.size();
    endfunction
  endclass

  // Clock, reset and every block input start at known values
  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic [31:0]          in_tdata   = '0;
  logic                 in_tuser   = 1'b0;
  logic                 in_tlast   = 1'b0;
  logic                 out_tready = 1'b0;
  logic                 cfg_valid  = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [7:0]           cfg_data   = '0;
  logic                 in_tready;
  logic                 out_tvalid;
  logic [31:0]          out_tdata;
  logic                 out_tlast;
  logic                 cfg_ready;

  colour_op_checker board;
  bit               hold_req    = 1'b0;  // ask the receiver for a long hold-off
  bit               steady_send = 1'b0;  // sender offers back to back, no gaps
  int unsigned      burst_left  = 0;

  masked_pixel_color_ops_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs
  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // Check every output transaction against the oldest owed pixel
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) board.check_pixel(out_tdata, out_tlast);
  end

  // Receiver: stretches of differing readiness, and one long hold-off on request.
  // Exactly one nonblocking write to out_tready per edge.
  initial begin : rx_stall
    int unsigned seg_left;
    int unsigned hold_left;
    rx_style_e   style;
    seg_left  = 0;
    hold_left = 0;
    style     = RX_ALWAYS;
    forever begin
      @(posedge clk);
      if (hold_left != 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (hold_req) begin
        // count the hold-off here so the sender keeps offering meanwhile
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        out_tready <= 1'b0;
      end else begin
        if (seg_left == 0) begin
          style    = rx_style_e'($urandom_range(0, 3));
          seg_left = $urandom_range(4, 48);
        end
        seg_left--;
        case (style)
          RX_ALWAYS: out_tready <= 1'b1;
          RX_HALF:   out_tready <= 1'($urandom_range(0, 1));
          RX_SPARSE: out_tready <= ($urandom_range(0, 3) == 0);
          default:   out_tready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  function automatic logic [7:0] pick_byte();
    // lean on the extremes now and then
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic pix_t px(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [7:0] a);
    pix_t p;
    p.red   = r;
    p.green = g;
    p.blue  = b;
    p.alpha = a;
    return p;
  endfunction

  // Offer one pixel and hold it until the block takes it. Opens a new burst,
  // with a random gap in front, once the current one is used up.
  // Called and returns on a rising edge.
  task automatic send_pixel(pix_t p, logic mask, logic last);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (steady_send || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= p;
    in_tuser  <= mask;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    board.note_pixel(p, mask, last);
  endtask

  // Drop valid and wait until every owed pixel has come back
  task automatic drain();
    in_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // One register write transaction; cfg_valid stays high for the next one
  task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    board.set_register(idx, data);
  endtask

  // Reprogram the whole register set with the block idle
  task automatic configure(logic [7:0] op_data, logic [7:0] r, logic [7:0] g,
                           logic [7:0] b, logic [7:0] a, logic [7:0] pct, bit spare);
    drain();
    set_reg(REG_OP_MODE, op_data);
    set_reg(REG_COLOR_RED, r);
    set_reg(REG_COLOR_GREEN, g);
    set_reg(REG_COLOR_BLUE, b);
    set_reg(REG_COLOR_ALPHA, a);
    set_reg(REG_DESAT_PCT, pct);
    if (spare) begin
      set_reg(REG_SPARE_6, 8'($urandom_range(0, 255)));
      set_reg(REG_SPARE_7, 8'($urandom_range(0, 255)));
    end
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    pix_t        p;
    op_t         op;
    logic [7:0]  pct_data;
    int unsigned phase;
    int unsigned n;
    board = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Out of reset: fill with transparent black
    send_pixel(px(8'hFF, 8'hFF, 8'hFF, 8'hFF), 1'b1, 1'b0);
    send_pixel(px(8'h5A, 8'hA5, 8'h3C, 8'hC3), 1'b0, 1'b1);

    // Fill; also poke the indexes beyond the register list
    configure(8'(OP_FILL), 8'hFF, 8'h00, 8'hFF, 8'h80, 8'h00, 1'b1);
    send_pixel(px(8'h00, 8'h00, 8'h00, 8'h00), 1'b1, 1'b0);
    send_pixel(px(8'hFF, 8'hFF, 8'hFF, 8'hFF), 1'b1, 1'b1);
    send_pixel(px(8'hFF, 8'hFF, 8'hFF, 8'hFF), 1'b0, 1'b0);

    // Paint with a clear colour; op written with its upper bits set
    configure({6'h3F, OP_PAINT}, 8'hFF, 8'h80, 8'h00, 8'h00, 8'h00, 1'b0);
    send_pixel(px(8'hFF, 8'hFF, 8'hFF, 8'hFF), 1'b1, 1'b0);
    send_pixel(px(8'h40, 8'h80, 8'hC0, 8'h7F), 1'b1, 1'b0);

    // Paint with an opaque colour
    configure(8'(OP_PAINT), 8'h12, 8'h34, 8'h56, 8'hFF, 8'h00, 1'b0);
    send_pixel(px(8'hAB, 8'hCD, 8'hEF, 8'h99), 1'b1, 1'b0);
    send_pixel(px(8'hAB, 8'hCD, 8'hEF, 8'h99), 1'b0, 1'b1);

    // Paint at half alpha across the pixel alpha extremes
    configure(8'(OP_PAINT), 8'hFF, 8'hFF, 8'hFF, 8'h80, 8'h00, 1'b0);
    send_pixel(px(8'hFF, 8'h00, 8'hFF, 8'h00), 1'b1, 1'b0);
    send_pixel(px(8'hFF, 8'hFF, 8'hFF, 8'hFF), 1'b1, 1'b0);
    send_pixel(px(8'h00, 8'h80, 8'hFF, 8'h80), 1'b1, 1'b0);

    // Full desaturation
    configure(8'(OP_DESAT), 8'h00, 8'h00, 8'h00, 8'h00, 8'd100, 1'b0);
    send_pixel(px(8'hFF, 8'h00, 8'h00, 8'h11), 1'b1, 1'b0);
    send_pixel(px(8'h00, 8'hFF, 8'h80, 8'hFF), 1'b1, 1'b0);
    send_pixel(px(8'h00, 8'hFF, 8'h80, 8'hFF), 1'b0, 1'b0);

    // Percent above one hundred saturates; top data bit is dropped
    configure(8'(OP_DESAT), 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 1'b0);
    send_pixel(px(8'd10, 8'd200, 8'd250, 8'h42), 1'b1, 1'b0);
    configure(8'(OP_DESAT), 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
    send_pixel(px(8'hFF, 8'hFF, 8'hFF, 8'hFF), 1'b1, 1'b0);
    configure(8'(OP_DESAT), 8'h00, 8'h00, 8'h00, 8'h00, 8'hB2, 1'b0);
    send_pixel(px(8'd7, 8'd99, 8'd201, 8'h00), 1'b1, 1'b1);

    // Extract
    configure(8'(OP_EXTRACT), 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h7F, 1'b0);
    send_pixel(px(8'hFF, 8'hFF, 8'hFF, 8'hFF), 1'b1, 1'b1);
    send_pixel(px(8'hFF, 8'hFF, 8'hFF, 8'hFF), 1'b0, 1'b0);
    send_pixel(px(8'h00, 8'h00, 8'h00, 8'h00), 1'b0, 1'b0);

    // Random passes, cycling through every operation
    for (phase = 0; phase < PHASES; phase++) begin
      op       = op_t'(phase % 4);
      pct_data = ($urandom_range(0, 3) == 0) ? 8'd100 : 8'($urandom_range(0, 255));
      configure({6'($urandom_range(0, 63)), op}, pick_byte(), pick_byte(), pick_byte(),
                pick_byte(), pct_data, $urandom_range(0, 2) == 0);
      steady_send = (phase == 2 || phase == 9);
      // stall the receiver while the sender keeps pushing, so the pipe backs up
      if (phase == 2) hold_req = 1'b1;
      for (n = 0; n < PHASE_PIXELS; n++) begin
        p = px(pick_byte(), pick_byte(), pick_byte(), pick_byte());
        send_pixel(p, $urandom_range(0, 3) != 0,
                   n == PHASE_PIXELS - 1 || $urandom_range(0, 15) == 0);
      end
    end
    steady_send = 1'b0;

    // Let the pipe empty, then watch for any stray output
    drain();
    repeat (20) @(posedge clk);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
